### hw/rtl/wmaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaa_pkg
// Shared types and codes for the waveform moving-average accumulator.
// ----------------------------------------------------------------------------
package wmaa_pkg;

    // Input opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_SEQUENCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RECORD_WORDS    = 2'd2;

    // Register reset values
    localparam logic [10:0] AVERAGE_COUNT_RST = 11'd1;
    localparam logic [12:0] RECORD_WORDS_RST  = 13'd4000;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample;
    } in_data_t;

    typedef struct packed {
        logic [11:0]        word_index;
        logic signed [31:0] accumulated_sum;
        logic               end_of_record;
        logic [10:0]        records_in_sum;
        logic [15:0]        acquisitions;
        logic               sequence_done;
    } out_data_t;

    // Work handed from the front to the back for one sample
    typedef struct packed {
        logic               fresh;          // old sum reads as zero
        logic               hist_rd;        // subtract oldest record's word
        logic               hist_wr;        // store sample in history ring
        logic signed [15:0] sample;
        logic [11:0]        word_index;
        logic               end_of_record;
        logic [10:0]        records_in_sum;
        logic [15:0]        acquisitions;
        logic               sequence_done;
    } wmaa_cmd_t;

endpackage

### hw/rtl/wmaa_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaa_fifo
// Small register queue between the front and the back of the accumulator.
// ----------------------------------------------------------------------------
module wmaa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/wmaa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaa_front
// Accepts transactions and configuration writes, tracks record position,
// window fill and counts, and issues one command per kept sample.
// ----------------------------------------------------------------------------
module wmaa_front #(
    parameter int RECORD_WORDS_MAX = 4096,
    parameter int MAX_RECORDS      = 16,
    parameter int AW               = 12,
    parameter int HAW              = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  wmaa_pkg::in_data_t                in_data,
    input  logic                              cfg_write,
    input  logic [wmaa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wmaa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              q_push,
    output wmaa_pkg::wmaa_cmd_t               q_cmd,
    output logic [AW-1:0]                     q_sum_addr,
    output logic [HAW-1:0]                    q_hist_addr,
    input  logic                              q_full
);

    localparam int LW = $clog2(RECORD_WORDS_MAX + 1);
    localparam int SW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int FW = $clog2(MAX_RECORDS + 1);

    logic [10:0]   avg_count_reg, avg_count_next;
    logic          single_reg, single_next;
    logic [12:0]   rec_words_reg, rec_words_next;
    logic [AW-1:0] word_pos_reg, word_pos_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [SW-1:0] oldest_reg, oldest_next;
    logic [10:0]   summed_reg, summed_next;
    logic [15:0]   acq_reg, acq_next;
    logic          fresh_reg, fresh_next;

    logic [10:0]   av;
    logic [LW-1:0] len;
    logic [AW-1:0] pos;
    logic [LW-1:0] pos_inc;
    logic          last;
    logic          full;
    logic          drop;
    logic [31:0]   slot_sel;
    logic [SW-1:0] slot;
    logic [10:0]   cnt_after;
    logic [15:0]   acq_inc;
    logic          accept;
    logic          restart;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // effective window length and record length
    always_comb
    begin
        av = (avg_count_reg == '0) ? 11'd1 : avg_count_reg;
        if (!single_reg && (32'(av) > 32'(MAX_RECORDS)))
        begin
            av = 11'(MAX_RECORDS);
        end
        if (rec_words_reg == '0)
        begin
            len = LW'(1);
        end
        else if (32'(rec_words_reg) > 32'(RECORD_WORDS_MAX))
        begin
            len = LW'(RECORD_WORDS_MAX);
        end
        else
        begin
            len = LW'(rec_words_reg);
        end
    end

    always_comb
    begin
        pos      = (LW'(word_pos_reg) >= len) ? '0 : word_pos_reg;
        pos_inc  = LW'(pos) + LW'(1);
        last     = (pos_inc >= len);
        full     = !single_reg && (32'(fill_reg) >= 32'(av));
        drop     = single_reg && (summed_reg >= av);
        slot_sel = full ? 32'(oldest_reg) : 32'(fill_reg);
        if (slot_sel >= 32'(MAX_RECORDS))
        begin
            slot_sel = '0;
        end
        slot      = SW'(slot_sel);
        cnt_after = full ? summed_reg : summed_reg + 11'd1;
        acq_inc   = acq_reg + 16'd1;
    end

    assign q_push      = accept && (in_data.opcode == wmaa_pkg::OP_SAMPLE) && !drop;
    assign q_sum_addr  = pos;
    assign q_hist_addr = HAW'(32'(slot) * 32'(RECORD_WORDS_MAX) + 32'(pos));

    always_comb
    begin
        q_cmd.fresh          = fresh_reg;
        q_cmd.hist_rd        = full;
        q_cmd.hist_wr        = !single_reg;
        q_cmd.sample         = in_data.sample;
        q_cmd.word_index     = 12'(pos);
        q_cmd.end_of_record  = last;
        q_cmd.records_in_sum = cnt_after;
        q_cmd.acquisitions   = acq_inc;
        q_cmd.sequence_done  = single_reg && (cnt_after >= av);
    end

    always_comb
    begin
        avg_count_next = avg_count_reg;
        single_next    = single_reg;
        rec_words_next = rec_words_reg;
        word_pos_next  = word_pos_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        summed_next    = summed_reg;
        acq_next       = acq_reg;
        fresh_next     = fresh_reg;
        restart        = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                wmaa_pkg::REG_AVERAGE_COUNT:
                begin
                    avg_count_next = cfg_data[10:0];
                    restart        = 1'b1;
                end
                wmaa_pkg::REG_SINGLE_SEQUENCE:
                begin
                    single_next = cfg_data[0];
                    restart     = 1'b1;
                end
                wmaa_pkg::REG_RECORD_WORDS:
                begin
                    rec_words_next = cfg_data;
                    restart        = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        else if (accept && (in_data.opcode == wmaa_pkg::OP_RESTART))
        begin
            restart = 1'b1;
        end
        else if (q_push)
        begin
            if (last)
            begin
                word_pos_next = '0;
                fresh_next    = 1'b0;
                summed_next   = cnt_after;
                acq_next      = acq_inc;
                if (!single_reg)
                begin
                    if (full)
                    begin
                        oldest_next = (32'(oldest_reg) + 32'd1 >= 32'(av)) ?
                                      '0 : oldest_reg + 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            else
            begin
                word_pos_next = AW'(pos_inc);
            end
        end

        if (restart)
        begin
            word_pos_next = '0;
            fill_next     = '0;
            oldest_next   = '0;
            summed_next   = '0;
            acq_next      = '0;
            fresh_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_count_reg <= wmaa_pkg::AVERAGE_COUNT_RST;
            single_reg    <= 1'b0;
            rec_words_reg <= wmaa_pkg::RECORD_WORDS_RST;
            word_pos_reg  <= '0;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            summed_reg    <= '0;
            acq_reg       <= '0;
            fresh_reg     <= 1'b1;
        end
        else
        begin
            avg_count_reg <= avg_count_next;
            single_reg    <= single_next;
            rec_words_reg <= rec_words_next;
            word_pos_reg  <= word_pos_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            summed_reg    <= summed_next;
            acq_reg       <= acq_next;
            fresh_reg     <= fresh_next;
        end
    end

endmodule

### hw/rtl/wmaa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaa_back
// Read-modify-write of the per-word sum memory and the history ring,
// with forwarding between adjacent commands, and the output register.
// ----------------------------------------------------------------------------
module wmaa_back #(
    parameter int RECORD_WORDS_MAX = 4096,
    parameter int MAX_RECORDS      = 16,
    parameter int AW               = 12,
    parameter int HAW              = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  wmaa_pkg::wmaa_cmd_t   q_cmd,
    input  logic [AW-1:0]         q_sum_addr,
    input  logic [HAW-1:0]        q_hist_addr,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wmaa_pkg::out_data_t   out_data
);

    localparam int SUM_DEPTH  = RECORD_WORDS_MAX;
    localparam int HIST_DEPTH = MAX_RECORDS * RECORD_WORDS_MAX;

    logic [31:0] sum_mem  [SUM_DEPTH];
    logic [15:0] hist_mem [HIST_DEPTH];

    logic                s1_valid_reg, s1_valid_next;
    wmaa_pkg::wmaa_cmd_t s1_cmd_reg;
    logic [AW-1:0]       s1_sum_addr_reg;
    logic [HAW-1:0]      s1_hist_addr_reg;
    logic [31:0]         sum_rd_reg;
    logic [15:0]         hist_rd_reg;
    logic                fwd_sum_hit_reg;
    logic [31:0]         fwd_sum_reg;
    logic                fwd_hist_hit_reg;
    logic [15:0]         fwd_hist_reg;
    logic                out_valid_reg, out_valid_next;
    wmaa_pkg::out_data_t out_data_reg;

    logic                adv;
    logic [31:0]         old_sum;
    logic [15:0]         old_hist;
    logic [31:0]         sub_term;
    logic [31:0]         acc;

    assign adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop = q_valid && (!s1_valid_reg || adv);

    // the command leaving s1 writes at the same edge the next one reads
    always_comb
    begin
        old_sum  = s1_cmd_reg.fresh ? '0 : (fwd_sum_hit_reg ? fwd_sum_reg : sum_rd_reg);
        old_hist = fwd_hist_hit_reg ? fwd_hist_reg : hist_rd_reg;
        sub_term = s1_cmd_reg.hist_rd ? {{16{old_hist[15]}}, old_hist} : '0;
        acc      = old_sum + {{16{s1_cmd_reg.sample[15]}}, s1_cmd_reg.sample} - sub_term;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_cmd_reg       <= q_cmd;
            s1_sum_addr_reg  <= q_sum_addr;
            s1_hist_addr_reg <= q_hist_addr;
            fwd_sum_hit_reg  <= adv && (s1_sum_addr_reg == q_sum_addr);
            fwd_sum_reg      <= acc;
            fwd_hist_hit_reg <= adv && s1_cmd_reg.hist_wr &&
                                (s1_hist_addr_reg == q_hist_addr);
            fwd_hist_reg     <= s1_cmd_reg.sample;
        end
        if (adv)
        begin
            out_data_reg.word_index      <= s1_cmd_reg.word_index;
            out_data_reg.accumulated_sum <= acc;
            out_data_reg.end_of_record   <= s1_cmd_reg.end_of_record;
            out_data_reg.records_in_sum  <= s1_cmd_reg.records_in_sum;
            out_data_reg.acquisitions    <= s1_cmd_reg.acquisitions;
            out_data_reg.sequence_done   <= s1_cmd_reg.sequence_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_mem[s1_sum_addr_reg] <= acc;
        end
        if (q_pop)
        begin
            sum_rd_reg <= sum_mem[q_sum_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_cmd_reg.hist_wr)
        begin
            hist_mem[s1_hist_addr_reg] <= s1_cmd_reg.sample;
        end
        if (q_pop)
        begin
            hist_rd_reg <= hist_mem[q_hist_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/waveform_moving_average_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_moving_average_accumulator
// Word-by-word record averager with moving-window and single-sequence modes.
// ----------------------------------------------------------------------------
//  channel   signals                              payload
//  input     in_valid / in_ready                  in_data (opcode, sample)
//  output    out_valid / out_ready                out_data (sum and record info)
//  config    cfg_write                            cfg_index, cfg_data
//
//  One sample per cycle sustained unless the output stalls; a result passes
//  the queue, s1 and the output register. The sum memory sets the rate:
//  one read and one write per word, with the adjacent write forwarded to
//  the following read. No clearing pass after reset: the first record after
//  a restart reads its old sums as zero. A four-entry queue lets input
//  continue while the output stalls; input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module waveform_moving_average_accumulator #(
    parameter int RECORD_WORDS_MAX = 4096,
    parameter int MAX_RECORDS      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  wmaa_pkg::in_data_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output wmaa_pkg::out_data_t               out_data,
    input  logic                              cfg_write,
    input  logic [wmaa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wmaa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW  = $clog2(RECORD_WORDS_MAX);
    localparam int HAW = $clog2(MAX_RECORDS * RECORD_WORDS_MAX);
    localparam int CMD_W = $bits(wmaa_pkg::wmaa_cmd_t);
    localparam int QW  = CMD_W + AW + HAW;

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    wmaa_pkg::wmaa_cmd_t push_cmd;
    logic [AW-1:0]       push_sum_addr;
    logic [HAW-1:0]      push_hist_addr;
    logic [QW-1:0]       pop_word;
    wmaa_pkg::wmaa_cmd_t pop_cmd;
    logic [AW-1:0]       pop_sum_addr;
    logic [HAW-1:0]      pop_hist_addr;

    wmaa_front #(
        .RECORD_WORDS_MAX (RECORD_WORDS_MAX),
        .MAX_RECORDS      (MAX_RECORDS),
        .AW               (AW),
        .HAW              (HAW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_sum_addr  (push_sum_addr),
        .q_hist_addr (push_hist_addr),
        .q_full      (q_full)
    );

    wmaa_fifo #(
        .WIDTH (QW),
        .DEPTH (wmaa_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_cmd, push_sum_addr, push_hist_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_word)
    );

    assign {pop_cmd, pop_sum_addr, pop_hist_addr} = pop_word;

    wmaa_back #(
        .RECORD_WORDS_MAX (RECORD_WORDS_MAX),
        .MAX_RECORDS      (MAX_RECORDS),
        .AW               (AW),
        .HAW              (HAW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (pop_cmd),
        .q_sum_addr  (pop_sum_addr),
        .q_hist_addr (pop_hist_addr),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_restart_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.opcode == wmaa_pkg::OP_RESTART)) |-> !q_push)
        else $error("restart transaction produced a command");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output transaction changed or dropped while waiting");
`endif

endmodule
